/* rtl/core/tpd_pkg.sv */
// Shared constants for the tablet packet decoder.
package tpd_pkg;

  // Field widths
  localparam int unsigned ByteW   = 7;   // stored byte width, bit 7 dropped
  localparam int unsigned DataW   = 6;   // data bits per packet byte
  localparam int unsigned BtnW    = 4;   // button bits on a flag byte
  localparam int unsigned RawW    = 12;  // joined coordinate width
  localparam int unsigned PtsW    = 13;  // points_per_side width
  localparam int unsigned PosXW   = 13;
  localparam int unsigned PosYW   = 14;
  localparam int unsigned FillW   = 3;
  localparam int unsigned WinDepth = 4;  // bytes held ahead of the current one

  // Bit positions inside a tablet byte
  localparam int unsigned FlagBit = 6;
  localparam int unsigned BtnLsb  = 2;

  // Scaling: v * points / 2200 = ((v * points) >> 3) / 275
  localparam int unsigned ProdW   = RawW + PtsW;         // 25
  localparam int unsigned PreShift = 3;
  localparam int unsigned NumW    = ProdW - PreShift;    // 22
  localparam int unsigned RecipShift = 31;
  localparam int unsigned RecipW  = 23;
  // ceil(2^31 / 275), exact floor division for every numerator below 2^22
  localparam logic [RecipW-1:0] Recip275 = 23'd7809032;
  localparam int unsigned QuotW   = 14;
  localparam int unsigned RecipProdW = NumW + RecipW;    // 45

  localparam logic [PtsW-1:0] PointsReset = 13'd512;
  localparam logic [FillW-1:0] FillFull   = 3'd4;
  localparam logic [PosXW-1:0] PosXMax    = 13'd8191;
  localparam int unsigned YDiffW = PosYW + 1;            // 15-bit signed difference
  localparam logic signed [YDiffW-1:0] PosYMin = -15'sd8192;

endpackage

/* rtl/core/tablet_packet_decoder_top.sv */
// Tablet packet decoder: byte window, packet choice, scaling pipeline, output register.
// Throughput: one byte per cycle while in_stall is low; a result may leave every cycle while out_stall is low.
// A batch's result goes from the capture at the edge that accepts its last byte
//   through the product, reciprocal multiply and output stages.
// in_stall rises only when the scaling pipeline is full and out_stall holds it.
// Synchronous active-high reset clears the batch state and all stage valids and
//   sets points_per_side to 512; pipeline payload registers are not reset.
module tablet_packet_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [tpd_pkg::PtsW-1:0]      cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    pad_byte,
  input  logic                          end_of_batch,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tpd_pkg::PosXW-1:0]     pos_x,
  output logic signed [tpd_pkg::PosYW-1:0] pos_y,
  output logic [tpd_pkg::BtnW-1:0]      button_bits,
  output logic                          found
);

  // Configuration and batch state
  logic [tpd_pkg::PtsW-1:0]  points_per_side;
  logic [tpd_pkg::ByteW-1:0] recent_bytes [tpd_pkg::WinDepth];
  logic [tpd_pkg::FillW-1:0] fill_count;
  logic [tpd_pkg::RawW-1:0]  chosen_x_raw;
  logic [tpd_pkg::RawW-1:0]  chosen_y_raw;
  logic [tpd_pkg::BtnW-1:0]  chosen_buttons;
  logic                      button_lock;
  logic                      have_packet;

  // Next values of the chosen packet, including the current byte
  logic [tpd_pkg::ByteW-1:0] byte_in;
  logic                      pkt_hit;
  logic [tpd_pkg::RawW-1:0]  hit_x;
  logic [tpd_pkg::RawW-1:0]  hit_y;
  logic [tpd_pkg::BtnW-1:0]  hit_btn;
  logic [tpd_pkg::RawW-1:0]  chosen_x_raw_next;
  logic [tpd_pkg::RawW-1:0]  chosen_y_raw_next;
  logic [tpd_pkg::BtnW-1:0]  chosen_buttons_next;
  logic                      button_lock_next;
  logic                      have_packet_next;
  logic [tpd_pkg::FillW-1:0] fill_count_next;

  // Pipeline stages
  logic                      s1_valid;
  logic [tpd_pkg::RawW-1:0]  s1_x_raw;
  logic [tpd_pkg::RawW-1:0]  s1_y_raw;
  logic [tpd_pkg::BtnW-1:0]  s1_btn;
  logic                      s1_found;

  logic                      s2_valid;
  logic [tpd_pkg::ProdW-1:0] s2_px;
  logic [tpd_pkg::ProdW-1:0] s2_py;
  logic [tpd_pkg::BtnW-1:0]  s2_btn;
  logic                      s2_found;

  logic                      s3_valid;
  logic [tpd_pkg::QuotW-1:0] s3_qx;
  logic [tpd_pkg::QuotW-1:0] s3_qy;
  logic [tpd_pkg::BtnW-1:0]  s3_btn;
  logic                      s3_found;

  logic adv1, adv2, adv3, adv_out;
  logic in_acc;
  logic s1_load;

  logic [tpd_pkg::RecipProdW-1:0]    rx_prod;
  logic [tpd_pkg::RecipProdW-1:0]    ry_prod;
  logic [tpd_pkg::PosXW-1:0]         pos_x_next;
  logic signed [tpd_pkg::YDiffW-1:0] y_diff;
  logic signed [tpd_pkg::PosYW-1:0]  pos_y_next;

  // Advance chain: a stage moves when it is empty or its successor moves
  assign adv_out  = !out_valid || !out_stall;
  assign adv3     = !s3_valid || adv_out;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;
  assign in_acc   = in_valid && !in_stall;
  assign s1_load  = in_acc && end_of_batch;

  // Detect a complete packet ending with the current byte and pick it
  always_comb begin
    byte_in = pad_byte[tpd_pkg::ByteW-1:0];
    pkt_hit = (fill_count == tpd_pkg::FillFull) &&
              recent_bytes[0][tpd_pkg::FlagBit] && !button_lock;
    hit_btn = recent_bytes[0][tpd_pkg::BtnLsb +: tpd_pkg::BtnW];
    hit_x   = {recent_bytes[2][tpd_pkg::DataW-1:0], recent_bytes[1][tpd_pkg::DataW-1:0]};
    hit_y   = {byte_in[tpd_pkg::DataW-1:0], recent_bytes[3][tpd_pkg::DataW-1:0]};
    chosen_x_raw_next   = pkt_hit ? hit_x : chosen_x_raw;
    chosen_y_raw_next   = pkt_hit ? hit_y : chosen_y_raw;
    chosen_buttons_next = pkt_hit ? hit_btn : chosen_buttons;
    button_lock_next    = button_lock || (pkt_hit && (hit_btn != '0));
    have_packet_next    = have_packet || pkt_hit;
    fill_count_next     = (fill_count == tpd_pkg::FillFull) ? fill_count
                                                            : fill_count + 3'd1;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      points_per_side <= tpd_pkg::PointsReset;
    end else if (cfg_wr_en) begin
      points_per_side <= cfg_wr_data;
    end
  end

  // Batch state: advance on each byte, clear after the last byte of a batch
  always_ff @(posedge clk) begin
    if (rst || (in_acc && end_of_batch)) begin
      for (int i = 0; i < tpd_pkg::WinDepth; i++) begin
        recent_bytes[i] <= '0;
      end
      fill_count     <= '0;
      chosen_x_raw   <= '0;
      chosen_y_raw   <= '0;
      chosen_buttons <= '0;
      button_lock    <= 1'b0;
      have_packet    <= 1'b0;
    end else if (in_acc) begin
      for (int i = 0; i < tpd_pkg::WinDepth - 1; i++) begin
        recent_bytes[i] <= recent_bytes[i+1];
      end
      recent_bytes[tpd_pkg::WinDepth-1] <= byte_in;
      fill_count     <= fill_count_next;
      chosen_x_raw   <= chosen_x_raw_next;
      chosen_y_raw   <= chosen_y_raw_next;
      chosen_buttons <= chosen_buttons_next;
      button_lock    <= button_lock_next;
      have_packet    <= have_packet_next;
    end
  end

  // Stage 1: capture the chosen packet of a finished batch
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= s1_load;
    end
    if (s1_load) begin
      s1_x_raw <= chosen_x_raw_next;
      s1_y_raw <= chosen_y_raw_next;
      s1_btn   <= chosen_buttons_next;
      s1_found <= have_packet_next;
    end
  end

  // Stage 2: multiply raw coordinates by the display size
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2 && s1_valid) begin
      s2_px    <= tpd_pkg::ProdW'(s1_x_raw) * tpd_pkg::ProdW'(points_per_side);
      s2_py    <= tpd_pkg::ProdW'(s1_y_raw) * tpd_pkg::ProdW'(points_per_side);
      s2_btn   <= s1_btn;
      s2_found <= s1_found;
    end
  end

  // Stage 3: divide by 2200 as a shift by 3 and a reciprocal multiply for 275
  assign rx_prod = tpd_pkg::RecipProdW'(s2_px[tpd_pkg::ProdW-1:tpd_pkg::PreShift]) *
                   tpd_pkg::RecipProdW'(tpd_pkg::Recip275);
  assign ry_prod = tpd_pkg::RecipProdW'(s2_py[tpd_pkg::ProdW-1:tpd_pkg::PreShift]) *
                   tpd_pkg::RecipProdW'(tpd_pkg::Recip275);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
    if (adv3 && s2_valid) begin
      s3_qx    <= rx_prod[tpd_pkg::RecipShift +: tpd_pkg::QuotW];
      s3_qy    <= ry_prod[tpd_pkg::RecipShift +: tpd_pkg::QuotW];
      s3_btn   <= s2_btn;
      s3_found <= s2_found;
    end
  end

  // Saturate x, form y = points - scaled value; the output register zeroes everything when no packet
  always_comb begin
    pos_x_next = s3_qx[tpd_pkg::QuotW-1] ? tpd_pkg::PosXMax
                                          : s3_qx[tpd_pkg::PosXW-1:0];
    y_diff = $signed({2'b00, points_per_side}) - $signed({1'b0, s3_qy});
    pos_y_next = (y_diff < tpd_pkg::PosYMin) ? tpd_pkg::PosYMin[tpd_pkg::PosYW-1:0]
                                             : y_diff[tpd_pkg::PosYW-1:0];
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s3_valid;
    end
    if (adv_out && s3_valid) begin
      pos_x       <= s3_found ? pos_x_next : '0;
      pos_y       <= s3_found ? pos_y_next : '0;
      button_bits <= s3_found ? s3_btn : '0;
      found       <= s3_found;
    end
  end

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> pos_x == '0 && pos_y == '0 && button_bits == '0)
    else $error("nonzero fields in a result without a packet");

  a_lock_has_packet: assert property (@(posedge clk) disable iff (rst)
    button_lock |-> have_packet)
    else $error("button lock without a chosen packet");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s2_valid && s3_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

  a_batch_cleared: assert property (@(posedge clk) disable iff (rst)
    in_acc && end_of_batch |=> fill_count == '0 && !have_packet)
    else $error("batch state not cleared after a batch end");

endmodule
